>>> hw/rtl/rhh_pkg.sv
// Shared types, widths and the divider step for the RGB to HSV/HSL converter.
package rhh_pkg;

    localparam int CH_W    = 16;
    localparam int DV_W    = CH_W + 3;
    localparam int OQ_DEPTH = 32;
    localparam int OQ_AW   = $clog2(OQ_DEPTH);
    localparam int MQ_DEPTH = 4;
    localparam int MQ_AW   = $clog2(MQ_DEPTH);

    localparam logic MODE_HSV = 1'b0;
    localparam logic MODE_HSL = 1'b1;

    typedef struct packed {
        logic [DV_W-1:0] hue_rem;
        logic [DV_W-1:0] hue_div;
        logic [DV_W-1:0] sat_rem;
        logic [CH_W-1:0] sat_lo;
        logic [DV_W-1:0] sat_div;
        logic [CH_W-1:0] third;
        logic [CH_W-1:0] alpha;
    } work_t;

    typedef struct packed {
        logic [CH_W-1:0] hue;
        logic [CH_W-1:0] sat;
        logic [CH_W-1:0] third;
        logic [CH_W-1:0] alpha;
    } result_t;

    typedef struct packed {
        logic            valid;
        logic [DV_W-1:0] hue_rem;
        logic [DV_W-1:0] hue_div;
        logic [CH_W-1:0] hue_q;
        logic [DV_W-1:0] sat_rem;
        logic [CH_W-1:0] sat_lo;
        logic [DV_W-1:0] sat_div;
        logic [CH_W-1:0] sat_q;
        logic [CH_W-1:0] third;
        logic [CH_W-1:0] alpha;
    } stage_t;

    // One restoring step: shift in a bit, subtract if it fits.
    function automatic logic [DV_W:0] div_step(logic [DV_W-1:0] rem, logic bit_in,
                                               logic [DV_W-1:0] dv);
        logic [DV_W:0] t;
        logic [DV_W:0] d;
        t = {rem, bit_in};
        d = {1'b0, dv};
        if (t >= d)
        begin
            t = t - d;
            return {1'b1, t[DV_W-1:0]};
        end
        return {1'b0, t[DV_W-1:0]};
    endfunction

endpackage

>>> hw/rtl/rhh_front.sv
// Front end: max/min/span, sector numerators and divisors, and a short queue to the back end.
module rhh_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 mode,
    input  logic                 push,
    output logic                 full,
    input  logic [rhh_pkg::CH_W-1:0] red,
    input  logic [rhh_pkg::CH_W-1:0] green,
    input  logic [rhh_pkg::CH_W-1:0] blue,
    input  logic [rhh_pkg::CH_W-1:0] alpha,
    output logic                 q_valid,
    input  logic                 q_take,
    output rhh_pkg::work_t       q_item
);
    import rhh_pkg::*;

    localparam logic [CH_W:0] FULL_S = {1'b0, {CH_W{1'b1}}};

    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] mn;
    logic [CH_W-1:0] span;
    logic [DV_W-1:0] span_w;
    logic [DV_W-1:0] num;
    logic [CH_W:0]   sum;
    logic [CH_W:0]   sdiv;
    logic [2*CH_W-1:0] prod;
    work_t           item;

    work_t           mem_reg [MQ_DEPTH];
    logic [MQ_AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [MQ_AW:0]  cnt_reg, cnt_next;
    logic            do_push;

    always_comb
    begin
        mx = red;
        mn = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;
        span   = mx - mn;
        span_w = DV_W'(span);
        if (red == mx)
        begin
            if (green >= blue)
                num = DV_W'(green - blue);
            else
                num = DV_W'(6) * span_w - DV_W'(blue - green);
        end
        else if (green == mx)
            num = DV_W'(2) * span_w + DV_W'(blue) - DV_W'(red);
        else
            num = DV_W'(4) * span_w + DV_W'(red) - DV_W'(green);
        sum  = {1'b0, mx} + {1'b0, mn};
        prod = {span, {CH_W{1'b0}}} - (2*CH_W)'(span);

        item.hue_rem = num;
        item.hue_div = (span == '0) ? DV_W'(1) : DV_W'(6) * span_w;
        item.sat_rem = DV_W'(prod[2*CH_W-1:CH_W]);
        item.sat_lo  = prod[CH_W-1:0];
        item.alpha   = alpha;
        if (mode == MODE_HSV)
        begin
            sdiv       = {1'b0, mx};
            item.third = mx;
        end
        else
        begin
            sdiv       = (sum <= FULL_S) ? sum : ((FULL_S << 1) - sum);
            item.third = sum[CH_W:1];
        end
        item.sat_div = (span == '0) ? DV_W'(1) : DV_W'(sdiv);
    end

    assign full    = (cnt_reg == (MQ_AW+1)'(MQ_DEPTH));
    assign do_push = push && !full;
    assign q_valid = (cnt_reg != '0);
    assign q_item  = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = do_push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = q_take ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (MQ_AW+1)'(do_push) - (MQ_AW+1)'(q_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wp_reg] <= item;
    end

endmodule

>>> hw/rtl/rhh_back.sv
// Back end: two pipelined restoring dividers, one quotient bit per stage, and the result queue.
module rhh_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_take,
    input  rhh_pkg::work_t   q_item,
    output logic             empty,
    input  logic             pop,
    output rhh_pkg::result_t res
);
    import rhh_pkg::*;

    stage_t          pipe_reg [CH_W+1];
    stage_t          pipe_next [CH_W+1];
    result_t         oq_reg [OQ_DEPTH];
    logic [OQ_AW-1:0] wp_reg, rp_reg;
    logic [OQ_AW:0]  oq_cnt_reg, oq_cnt_next;
    logic [OQ_AW:0]  credit_reg, credit_next;
    logic            do_pop;
    logic [DV_W:0]   sh, ss;

    assign do_pop = pop && !empty;
    assign empty  = (oq_cnt_reg == '0);
    assign res    = oq_reg[rp_reg];
    // Issue only when the result queue has room for everything in flight.
    assign q_take = q_valid && (credit_reg != (OQ_AW+1)'(OQ_DEPTH));

    always_comb
    begin
        pipe_next[0].valid   = q_take;
        pipe_next[0].hue_rem = q_item.hue_rem;
        pipe_next[0].hue_div = q_item.hue_div;
        pipe_next[0].hue_q   = '0;
        pipe_next[0].sat_rem = q_item.sat_rem;
        pipe_next[0].sat_lo  = q_item.sat_lo;
        pipe_next[0].sat_div = q_item.sat_div;
        pipe_next[0].sat_q   = '0;
        pipe_next[0].third   = q_item.third;
        pipe_next[0].alpha   = q_item.alpha;
        sh = '0;
        ss = '0;
        for (int i = 1; i <= CH_W; i++)
        begin
            sh = div_step(pipe_reg[i-1].hue_rem, 1'b0, pipe_reg[i-1].hue_div);
            ss = div_step(pipe_reg[i-1].sat_rem, pipe_reg[i-1].sat_lo[CH_W-1],
                          pipe_reg[i-1].sat_div);
            pipe_next[i]         = pipe_reg[i-1];
            pipe_next[i].hue_rem = sh[DV_W-1:0];
            pipe_next[i].hue_q   = {pipe_reg[i-1].hue_q[CH_W-2:0], sh[DV_W]};
            pipe_next[i].sat_rem = ss[DV_W-1:0];
            pipe_next[i].sat_lo  = {pipe_reg[i-1].sat_lo[CH_W-2:0], 1'b0};
            pipe_next[i].sat_q   = {pipe_reg[i-1].sat_q[CH_W-2:0], ss[DV_W]};
        end
        oq_cnt_next = oq_cnt_reg + (OQ_AW+1)'(pipe_reg[CH_W].valid)
                      - (OQ_AW+1)'(do_pop);
        credit_next = credit_reg + (OQ_AW+1)'(q_take) - (OQ_AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= CH_W; i++)
                pipe_reg[i] <= '0;
            wp_reg     <= '0;
            rp_reg     <= '0;
            oq_cnt_reg <= '0;
            credit_reg <= '0;
        end
        else
        begin
            for (int i = 0; i <= CH_W; i++)
                pipe_reg[i] <= pipe_next[i];
            if (pipe_reg[CH_W].valid)
                wp_reg <= wp_reg + 1'b1;
            if (do_pop)
                rp_reg <= rp_reg + 1'b1;
            oq_cnt_reg <= oq_cnt_next;
            credit_reg <= credit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_reg[CH_W].valid)
        begin
            oq_reg[wp_reg].hue   <= pipe_reg[CH_W].hue_q;
            oq_reg[wp_reg].sat   <= pipe_reg[CH_W].sat_q;
            oq_reg[wp_reg].third <= pipe_reg[CH_W].third;
            oq_reg[wp_reg].alpha <= pipe_reg[CH_W].alpha;
        end
    end

endmodule

>>> hw/rtl/rgb_to_hsv_hsl.sv
// Path: push, front queue, issue to stage 0, divider stages, result queue (empty low).
// Throughput: one pixel per cycle while results are popped and credits remain; each
// divider stage yields one quotient bit, and the 32-entry result queue with issue
// credits keeps the divider pipeline full. Reset: rst_n asynchronous, active low;
// clears the queues, the pipeline valids and mode_reg (HSV).
module rgb_to_hsv_hsl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_data,
    input  logic                     push,
    output logic                     full,
    input  logic [rhh_pkg::CH_W-1:0] red,
    input  logic [rhh_pkg::CH_W-1:0] green,
    input  logic [rhh_pkg::CH_W-1:0] blue,
    input  logic [rhh_pkg::CH_W-1:0] alpha,
    output logic                     empty,
    input  logic                     pop,
    output logic [rhh_pkg::CH_W-1:0] hue_out,
    output logic [rhh_pkg::CH_W-1:0] saturation_out,
    output logic [rhh_pkg::CH_W-1:0] value_or_lightness,
    output logic [rhh_pkg::CH_W-1:0] alpha_out
);
    import rhh_pkg::*;

    logic    mode_reg;
    logic    q_valid;
    logic    q_take;
    work_t   q_item;
    result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_HSV;
        else if (cfg_we)
            mode_reg <= cfg_data;
    end

    rhh_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .mode    (mode_reg),
        .push    (push),
        .full    (full),
        .red     (red),
        .green   (green),
        .blue    (blue),
        .alpha   (alpha),
        .q_valid (q_valid),
        .q_take  (q_take),
        .q_item  (q_item)
    );

    rhh_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_take  (q_take),
        .q_item  (q_item),
        .empty   (empty),
        .pop     (pop),
        .res     (res)
    );

    assign hue_out            = res.hue;
    assign saturation_out     = res.sat;
    assign value_or_lightness = res.third;
    assign alpha_out          = res.alpha;

endmodule
